// File: rtl/ncps_pkg.sv
//------------------------------------------------------------------------------
// ncps_pkg
// Shared types and constants for the nearest-centroid probe selection core.
//------------------------------------------------------------------------------
package ncps_pkg;

	localparam int MaxLists  = 256;
	localparam int MaxDim    = 128;
	localparam int MaxProbes = 16;

	localparam int ListW   = $clog2(MaxLists);
	localparam int ElemW   = $clog2(MaxDim);
	localparam int ProbeW  = $clog2(MaxProbes);
	localparam int CentAw  = ListW + ElemW;
	localparam int DistW   = 40;

	localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

	localparam logic [1:0] RegDim    = 2'd0;
	localparam logic [1:0] RegLists  = 2'd1;
	localparam logic [1:0] RegProbes = 2'd2;

	localparam logic ReqLoad  = 1'b0;
	localparam logic ReqQuery = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  list_index;
		logic [6:0]  elem_index;
		logic signed [15:0] elem_value;
		logic [4:0]  probe_override;
		logic        query_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  nearest_list;
		logic [39:0] sq_distance;
		logic        last_result;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_INS,
		ST_EMIT
	} state_t;

endpackage

// File: rtl/ncps_ram.sv
//------------------------------------------------------------------------------
// ncps_ram
// Generic single-port-write, single-port-read RAM with registered read.
//------------------------------------------------------------------------------
module ncps_ram #(
	parameter int Width = 16,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/nearest_centroid_probe_select_core.sv
//------------------------------------------------------------------------------
// nearest_centroid_probe_select_core
// Coarse quantizer: squared L2 distance to every configured centroid list, nearest few out.
//------------------------------------------------------------------------------
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_ready  | ncps_pkg::in_item_t
// out     | out | out_valid/out_ready| ncps_pkg::out_item_t
// apb     | in  | psel/penable/pready| paddr, pwdata, prdata
//
// Load and plain query items are taken while idle. A query end starts the search,
// paced by the single centroid memory read port: dim reads per list, a wait for
// the last read data, then one insert step per list; each result is then emitted
// when out_ready is high.
// Reset clears control state and configuration registers only; memories, the
// accumulator and the best list are not cleared. A stalled output holds the
// current result; no input is taken until all results leave.
//------------------------------------------------------------------------------
module nearest_centroid_probe_select_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ncps_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ncps_pkg::out_item_t  out_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int LW = ncps_pkg::ListW;
	localparam int EW = ncps_pkg::ElemW;
	localparam int PW = ncps_pkg::ProbeW;
	localparam int DW = ncps_pkg::DistW;

	logic [7:0] dim_q;
	logic [8:0] lists_q;
	logic [4:0] dprobes_q;

	ncps_pkg::state_t state_q, state_d;

	// search control
	logic [LW:0]   list_q;
	logic [EW:0]   elem_q;
	logic          rd_s1;
	logic          rdlast_s1;
	logic [DW-1:0] acc_q;
	logic [DW-1:0] dist_q;
	logic [PW:0]   count_q;
	logic [PW:0]   keep_q;
	logic [PW:0]   emit_q;
	logic [EW:0]   dim_eff;
	logic [LW:0]   lists_eff;

	logic [LW-1:0] bidx_q  [ncps_pkg::MaxProbes];
	logic [DW-1:0] bdist_q [ncps_pkg::MaxProbes];

	// memories
	logic              cent_we, qry_we;
	logic [15:0]       cent_rd, qry_rd;
	logic [LW+EW-1:0]  cent_raddr;
	logic [EW-1:0]     qry_raddr;

	logic in_acc, is_load, load_ok, q_ok;

	assign pready  = 1'b1;
	assign in_acc  = in_valid && in_ready;
	assign is_load = (in_data.req_type == ncps_pkg::ReqLoad);
	assign load_ok = {1'b0, in_data.list_index} < 9'(ncps_pkg::MaxLists)
		&& {1'b0, in_data.elem_index} < 8'(ncps_pkg::MaxDim);
	assign q_ok    = {1'b0, in_data.elem_index} < 8'(ncps_pkg::MaxDim);
	assign cent_we = in_acc && is_load && load_ok;
	assign qry_we  = in_acc && !is_load && q_ok;

	assign cent_raddr = {list_q[LW-1:0], elem_q[EW-1:0]};
	assign qry_raddr  = elem_q[EW-1:0];

	ncps_ram #(.Width(16), .Depth(ncps_pkg::MaxLists * ncps_pkg::MaxDim)) u_cent (
		.clk(clk), .we(cent_we),
		.waddr({in_data.list_index[LW-1:0], in_data.elem_index[EW-1:0]}),
		.wdata(in_data.elem_value), .raddr(cent_raddr), .rdata(cent_rd)
	);

	ncps_ram #(.Width(16), .Depth(ncps_pkg::MaxDim)) u_qry (
		.clk(clk), .we(qry_we), .waddr(in_data.elem_index[EW-1:0]),
		.wdata(in_data.elem_value), .raddr(qry_raddr), .rdata(qry_rd)
	);

	// register clamps
	always_comb begin
		if (dim_q == 8'd0) dim_eff = (EW+1)'(1);
		else if ({1'b0, dim_q} > 9'(ncps_pkg::MaxDim)) dim_eff = (EW+1)'(ncps_pkg::MaxDim);
		else dim_eff = (EW+1)'(dim_q);
		if (lists_q == 9'd0) lists_eff = (LW+1)'(1);
		else if ({1'b0, lists_q} > 10'(ncps_pkg::MaxLists))
			lists_eff = (LW+1)'(ncps_pkg::MaxLists);
		else lists_eff = (LW+1)'(lists_q);
	end

	// probe count for the ending query item
	logic [4:0]  pr_raw;
	logic [PW:0] pr_clamp;
	always_comb begin
		pr_raw = (in_data.probe_override != 5'd0) ? in_data.probe_override : dprobes_q;
		if (pr_raw == 5'd0) pr_raw = 5'd1;
		if ({1'b0, pr_raw} > 6'(ncps_pkg::MaxProbes)) pr_clamp = (PW+1)'(ncps_pkg::MaxProbes);
		else pr_clamp = (PW+1)'(pr_raw);
		if ({{(LW-PW){1'b0}}, pr_clamp} > lists_eff) pr_clamp = (PW+1)'(lists_eff);
	end

	// APB
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q     <= 8'd128;
			lists_q   <= 9'd256;
			dprobes_q <= 5'd1;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				ncps_pkg::RegDim:    dim_q     <= pwdata[7:0];
				ncps_pkg::RegLists:  lists_q   <= pwdata[8:0];
				ncps_pkg::RegProbes: dprobes_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			ncps_pkg::RegDim:    prdata = {24'd0, dim_q};
			ncps_pkg::RegLists:  prdata = {23'd0, lists_q};
			ncps_pkg::RegProbes: prdata = {27'd0, dprobes_q};
			default:             prdata = 32'd0;
		endcase
	end

	// square of the element difference, saturating add
	logic signed [16:0] diff;
	logic [33:0]        sq;
	logic [DW:0]        sum;
	assign diff = 17'(signed'(qry_rd)) - 17'(signed'(cent_rd));
	assign sq   = 34'(diff * diff);
	assign sum  = {1'b0, acc_q} + (DW+1)'(sq);

	// insertion position: count of entries not greater than dist
	logic [PW:0] pos;
	always_comb begin
		pos = '0;
		for (int i = 0; i < ncps_pkg::MaxProbes; i++) begin
			if ((PW+1)'(i) < count_q && !(dist_q < bdist_q[i])) pos = pos + 1'b1;
		end
	end

	logic last_elem;
	assign last_elem = (elem_q == dim_eff - 1'b1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ncps_pkg::ST_IDLE:
				if (in_acc && !is_load && in_data.query_end) state_d = ncps_pkg::ST_ACC;
			ncps_pkg::ST_ACC:
				if (rd_s1 && rdlast_s1) state_d = ncps_pkg::ST_INS;
			ncps_pkg::ST_INS:
				if (list_q == lists_eff) state_d = ncps_pkg::ST_EMIT;
				else state_d = ncps_pkg::ST_ACC;
			ncps_pkg::ST_EMIT:
				if (out_ready && emit_q == count_q - 1'b1) state_d = ncps_pkg::ST_IDLE;
			default: state_d = ncps_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ncps_pkg::ST_IDLE);
		out_valid = (state_q == ncps_pkg::ST_EMIT);
		out_data.nearest_list = 8'(bidx_q[emit_q[PW-1:0]]);
		out_data.sq_distance  = bdist_q[emit_q[PW-1:0]];
		out_data.last_result  = (emit_q == count_q - 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ncps_pkg::ST_IDLE;
			list_q    <= '0;
			elem_q    <= '0;
			rd_s1     <= 1'b0;
			rdlast_s1 <= 1'b0;
			count_q   <= '0;
			keep_q    <= '0;
			emit_q    <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ncps_pkg::ST_IDLE: begin
					list_q  <= '0;
					elem_q  <= '0;
					count_q <= '0;
					emit_q  <= '0;
					rd_s1   <= 1'b0;
					keep_q  <= pr_clamp;
				end
				ncps_pkg::ST_ACC: begin
					// issue reads until the last element, then wait for data
					if (!(rd_s1 && rdlast_s1) && !(rdlast_s1 && !rd_s1)) begin
						rd_s1     <= 1'b1;
						rdlast_s1 <= last_elem;
						if (last_elem) begin
							elem_q <= '0;
							list_q <= list_q + 1'b1;
						end else begin
							elem_q <= elem_q + 1'b1;
						end
					end
					if (rdlast_s1 && rd_s1) rd_s1 <= 1'b0;
				end
				ncps_pkg::ST_INS: begin
					rdlast_s1 <= 1'b0;
					if (pos < keep_q && count_q < keep_q) count_q <= count_q + 1'b1;
				end
				ncps_pkg::ST_EMIT:
					if (out_ready) emit_q <= emit_q + 1'b1;
				default: ;
			endcase
		end
	end

	// accumulator and best list payload
	always_ff @(posedge clk) begin
		if (state_q == ncps_pkg::ST_IDLE || state_q == ncps_pkg::ST_INS) begin
			acc_q <= '0;
		end else if (state_q == ncps_pkg::ST_ACC && rd_s1) begin
			acc_q <= sum[DW] ? ncps_pkg::DistMax : sum[DW-1:0];
			if (rdlast_s1) dist_q <= sum[DW] ? ncps_pkg::DistMax : sum[DW-1:0];
		end
		if (state_q == ncps_pkg::ST_INS && pos < keep_q) begin
			for (int i = 0; i < ncps_pkg::MaxProbes; i++) begin
				if ((PW+1)'(i) == pos) begin
					bidx_q[i]  <= LW'(list_q - 1'b1);
					bdist_q[i] <= dist_q;
				end else if ((PW+1)'(i) > pos && i > 0) begin
					bidx_q[i]  <= bidx_q[(i > 0) ? i - 1 : 0];
					bdist_q[i] <= bdist_q[(i > 0) ? i - 1 : 0];
				end
			end
		end
	end

endmodule
